>>> src/sv32at_pkg.sv
// shared types, constants and codes for the sv32 address translation block
`default_nettype none

package sv32at_pkg;

  localparam int unsigned POOL_TABLES   = 4;
  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned ROOT_AW       = $clog2(TABLE_ENTRIES);
  localparam int unsigned LEAF_DEPTH    = POOL_TABLES * TABLE_ENTRIES;
  localparam int unsigned LEAF_AW       = $clog2(LEAF_DEPTH);
  localparam int unsigned POOL_W        = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int unsigned XLEN          = 32;

  localparam int unsigned FLAG_V = 0;
  localparam int unsigned FLAG_R = 1;
  localparam int unsigned FLAG_W = 2;
  localparam int unsigned FLAG_X = 3;
  localparam int unsigned FLAG_U = 4;

  localparam logic CFG_XLATE_EN  = 1'b0;
  localparam logic CFG_SATP_MODE = 1'b1;

  typedef enum logic [1:0] {
    OP_XLATE   = 2'd0,
    OP_ROOT_WR = 2'd1,
    OP_LEAF_WR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    FLT_NONE  = 2'd0,
    FLT_INST  = 2'd1,
    FLT_LOAD  = 2'd2,
    FLT_STORE = 2'd3
  } fault_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROOT,
    ST_LEAF
  } state_e;

  typedef struct packed {
    logic               re;
    logic               we;
    logic [ROOT_AW-1:0] addr;
    logic [XLEN-1:0]    wdata;
  } root_req_t;

  typedef struct packed {
    logic               re;
    logic               we;
    logic [LEAF_AW-1:0] addr;
    logic [XLEN-1:0]    wdata;
  } leaf_req_t;

endpackage

`default_nettype wire

>>> src/sv32at_ram.sv
// generic single-port synchronous ram with registered read data
`default_nettype none

module sv32at_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             re_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/sv32at_walk.sv
// walk sequencer: table clearing, entry writes, two-level lookup and result register
`default_nettype none

module sv32at_walk
  import sv32at_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       op_i,
  input  wire logic [XLEN-1:0]  vaddr_i,
  input  wire logic             is_write_i,
  input  wire logic             is_exec_i,
  input  wire logic             user_mode_i,
  input  wire logic [1:0]       table_slot_i,
  input  wire logic [9:0]       entry_index_i,
  input  wire logic [XLEN-1:0]  entry_value_i,
  input  wire logic             xlate_on_i,
  output root_req_t             root_req_o,
  input  wire logic [XLEN-1:0]  root_rdata_i,
  output leaf_req_t             leaf_req_o,
  input  wire logic [XLEN-1:0]  leaf_rdata_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [XLEN-1:0]  phys_addr_o,
  output logic      [1:0]       fault_o
);

  state_e             state_q, state_d;
  logic [LEAF_AW-1:0] clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  logic [XLEN-1:0]    pa_q;
  fault_e             flt_q;
  logic [XLEN-1:0]    va_q;
  logic               wr_q, ex_q, usr_q;

  logic               in_fire;
  logic               res_load;
  logic [XLEN-1:0]    res_pa;
  fault_e             res_flt;
  fault_e             kind;
  logic [19:0]        dir_frame;
  logic               dir_v, dir_super, frame_ok, dir_next;
  logic               leaf_v, slot_ok;

  assign in_fire   = in_valid_i && in_ready_o;
  assign kind      = ex_q ? FLT_INST : (wr_q ? FLT_STORE : FLT_LOAD);
  assign dir_frame = root_rdata_i[31:12];
  assign dir_v     = root_rdata_i[FLAG_V];
  assign dir_super = root_rdata_i[FLAG_R] || root_rdata_i[FLAG_W] || root_rdata_i[FLAG_X];
  assign frame_ok  = 32'(dir_frame) < 32'(POOL_TABLES);
  assign dir_next  = dir_v && !dir_super && frame_ok;
  assign leaf_v    = leaf_rdata_i[FLAG_V];
  assign slot_ok   = 32'(table_slot_i) < 32'(POOL_TABLES);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LEAF_AW'(LEAF_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire && (op_i == OP_XLATE) && xlate_on_i) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        state_d = dir_next ? ST_LEAF : ST_IDLE;
      end
      ST_LEAF: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs and memory requests
  always_comb begin
    in_ready_o = 1'b0;
    root_req_o = '0;
    leaf_req_o = '0;
    res_load   = 1'b0;
    res_pa     = '0;
    res_flt    = FLT_NONE;
    clr_d      = clr_q;
    case (state_q)
      ST_CLEAR: begin
        root_req_o.we   = 1'b1;
        root_req_o.addr = clr_q[ROOT_AW-1:0];
        leaf_req_o.we   = 1'b1;
        leaf_req_o.addr = clr_q;
        clr_d           = clr_q + 1'b1;
      end
      ST_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        if (in_fire) begin
          case (op_i)
            OP_XLATE: begin
              if (xlate_on_i) begin
                root_req_o.re   = 1'b1;
                root_req_o.addr = vaddr_i[31:22];
              end else begin
                res_load = 1'b1;
                res_pa   = vaddr_i;
              end
            end
            OP_ROOT_WR: begin
              root_req_o.we    = 1'b1;
              root_req_o.addr  = entry_index_i;
              root_req_o.wdata = entry_value_i;
              res_load         = 1'b1;
            end
            OP_LEAF_WR: begin
              leaf_req_o.we    = slot_ok;
              leaf_req_o.addr  = LEAF_AW'({table_slot_i, entry_index_i});
              leaf_req_o.wdata = entry_value_i;
              res_load         = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_ROOT: begin
        if (!dir_v) begin
          res_load = 1'b1;
          res_flt  = kind;
        end else if (dir_super) begin
          res_load = 1'b1;
          res_pa   = {root_rdata_i[31:22], va_q[21:0]};
        end else if (!frame_ok) begin
          res_load = 1'b1;
          res_flt  = kind;
        end else begin
          leaf_req_o.re   = 1'b1;
          leaf_req_o.addr = LEAF_AW'({dir_frame[POOL_W-1:0], va_q[21:12]});
        end
      end
      ST_LEAF: begin
        res_load = 1'b1;
        if (!leaf_v) begin
          res_flt = kind;
        end else if (wr_q && !leaf_rdata_i[FLAG_W]) begin
          res_flt = FLT_STORE;
        end else if (ex_q && !leaf_rdata_i[FLAG_X]) begin
          res_flt = FLT_INST;
        end else if (usr_q && !leaf_rdata_i[FLAG_U]) begin
          res_flt = kind;
        end else begin
          res_pa = {leaf_rdata_i[31:12], va_q[11:0]};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = res_load ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      pa_q  <= res_pa;
      flt_q <= res_flt;
    end
    if (in_fire) begin
      va_q  <= vaddr_i;
      wr_q  <= is_write_i;
      ex_q  <= is_exec_i;
      usr_q <= user_mode_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign phys_addr_o = pa_q;
  assign fault_o     = flt_q;

endmodule

`default_nettype wire

>>> src/sv32_address_translation_top.sv
// top level of the sv32 address translation block: config registers, tables, walker
//
//   channel  direction  handshake                beat payload
//   cfg      in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//   in       in         in_valid_i/in_ready_o    op, vaddr, access kind, table write fields
//   out      out        out_valid_o/out_ready_i  phys_addr, fault
//
// entry writes, bare translations and op 3 load the result register from idle; a walk that
// ends at the root entry passes through the root state and a full walk through the root and
// leaf states, set by the dependent root and second-level reads through their synchronous rams
// after reset a clearing pass over all POOL_TABLES*1024 leaf addresses (4096) zeroes both
// tables, during which no input beat is taken; config beats are always taken
// the result register holds a beat until taken; a new input beat is taken in that same cycle
`default_nettype none

module sv32_address_translation_top
  import sv32at_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic            cfg_index_i,
  input  wire logic            cfg_data_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [1:0]      op_i,
  input  wire logic [XLEN-1:0] vaddr_i,
  input  wire logic            is_write_i,
  input  wire logic            is_exec_i,
  input  wire logic            user_mode_i,
  input  wire logic [1:0]      table_slot_i,
  input  wire logic [9:0]      entry_index_i,
  input  wire logic [XLEN-1:0] entry_value_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic      [XLEN-1:0] phys_addr_o,
  output logic      [1:0]      fault_o
);

  logic            xlate_en_q, xlate_en_d;
  logic            satp_mode_q, satp_mode_d;
  root_req_t       root_req;
  leaf_req_t       leaf_req;
  logic [XLEN-1:0] root_rdata, leaf_rdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    xlate_en_d  = xlate_en_q;
    satp_mode_d = satp_mode_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_XLATE_EN:  xlate_en_d  = cfg_data_i;
        CFG_SATP_MODE: satp_mode_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xlate_en_q  <= 1'b0;
      satp_mode_q <= 1'b0;
    end else begin
      xlate_en_q  <= xlate_en_d;
      satp_mode_q <= satp_mode_d;
    end
  end

  sv32at_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (XLEN)
  ) u_root_ram (
    .clk_i   (clk_i),
    .re_i    (root_req.re),
    .we_i    (root_req.we),
    .addr_i  (root_req.addr),
    .wdata_i (root_req.wdata),
    .rdata_o (root_rdata)
  );

  sv32at_ram #(
    .DEPTH (LEAF_DEPTH),
    .WIDTH (XLEN)
  ) u_leaf_ram (
    .clk_i   (clk_i),
    .re_i    (leaf_req.re),
    .we_i    (leaf_req.we),
    .addr_i  (leaf_req.addr),
    .wdata_i (leaf_req.wdata),
    .rdata_o (leaf_rdata)
  );

  sv32at_walk u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .vaddr_i       (vaddr_i),
    .is_write_i    (is_write_i),
    .is_exec_i     (is_exec_i),
    .user_mode_i   (user_mode_i),
    .table_slot_i  (table_slot_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .xlate_on_i    (xlate_en_q && satp_mode_q),
    .root_req_o    (root_req),
    .root_rdata_i  (root_rdata),
    .leaf_req_o    (leaf_req),
    .leaf_rdata_i  (leaf_rdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .phys_addr_o   (phys_addr_o),
    .fault_o       (fault_o)
  );

endmodule

`default_nettype wire

>>> tb/sv32at_checker.sv
// checker for the sv32 address translation block: table and config shadow, walk prediction, compare
`default_nettype none

module sv32at_checker
  import sv32at_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_valid_i,
  input  wire logic            cfg_ready_i,
  input  wire logic            cfg_index_i,
  input  wire logic            cfg_data_i,
  input  wire logic            in_valid_i,
  input  wire logic            in_ready_i,
  input  wire logic [1:0]      op_i,
  input  wire logic [XLEN-1:0] vaddr_i,
  input  wire logic            is_write_i,
  input  wire logic            is_exec_i,
  input  wire logic            user_mode_i,
  input  wire logic [1:0]      table_slot_i,
  input  wire logic [9:0]      entry_index_i,
  input  wire logic [XLEN-1:0] entry_value_i,
  input  wire logic            out_valid_i,
  input  wire logic            out_ready_i,
  input  wire logic [XLEN-1:0] phys_addr_i,
  input  wire logic [1:0]      fault_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic [XLEN-1:0] phys_addr;
    fault_e          fault;
  } xlat_result_t;

  logic [XLEN-1:0] root_pte [TABLE_ENTRIES];
  logic [XLEN-1:0] leaf_pte [LEAF_DEPTH];
  logic            xlate_en;
  logic            satp_mode;
  xlat_result_t    expected_xlat [$];
  int unsigned     fail_count = 0;
  int unsigned     pending_cnt = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_cnt;

  task automatic report_mismatch(input string what, input logic [XLEN-1:0] got,
                                 input logic [XLEN-1:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    fail_count++;
  endtask

  // two-level walk as the block should do it, on the shadow tables
  function automatic xlat_result_t walk_page_tables(input logic [XLEN-1:0] va,
                                                    input logic wr, input logic ex,
                                                    input logic usr);
    xlat_result_t    r;
    fault_e          kind;
    logic [XLEN-1:0] dir;
    logic [XLEN-1:0] leaf;
    logic [19:0]     frame;
    r.phys_addr = '0;
    r.fault     = FLT_NONE;
    kind = ex ? FLT_INST : (wr ? FLT_STORE : FLT_LOAD);
    if (!(xlate_en && satp_mode)) begin
      r.phys_addr = va;
    end else begin
      dir   = root_pte[va[31:22]];
      frame = dir[31:12];
      if (!dir[FLAG_V]) begin
        r.fault = kind;
      end else if (dir[FLAG_R] || dir[FLAG_W] || dir[FLAG_X]) begin
        r.phys_addr = {dir[31:22], va[21:0]};
      end else if (frame >= POOL_TABLES) begin
        r.fault = kind;
      end else begin
        leaf = leaf_pte[int'(frame) * TABLE_ENTRIES + int'(va[21:12])];
        if (!leaf[FLAG_V]) r.fault = kind;
        else if (wr && !leaf[FLAG_W]) r.fault = FLT_STORE;
        else if (ex && !leaf[FLAG_X]) r.fault = FLT_INST;
        else if (usr && !leaf[FLAG_U]) r.fault = kind;
        else r.phys_addr = {leaf[31:12], va[11:0]};
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    xlat_result_t want;
    xlat_result_t res;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) root_pte[i] = '0;
      for (int i = 0; i < LEAF_DEPTH; i++) leaf_pte[i] = '0;
      xlate_en  = 1'b0;
      satp_mode = 1'b0;
      expected_xlat.delete();
      pending_cnt = 0;
    end else begin
      // result beat
      if (out_valid_i && out_ready_i) begin
        if (expected_xlat.size() == 0) begin
          report_mismatch("result beat with none expected", phys_addr_i, '0);
        end else begin
          want = expected_xlat.pop_front();
          if (phys_addr_i !== want.phys_addr) begin
            report_mismatch("phys_addr", phys_addr_i, want.phys_addr);
          end
          if (fault_i !== want.fault) begin
            report_mismatch("fault", XLEN'(fault_i), XLEN'(want.fault));
          end
        end
      end
      // input beat
      if (in_valid_i && in_ready_i) begin
        res = '0;
        case (op_i)
          OP_XLATE: res = walk_page_tables(vaddr_i, is_write_i, is_exec_i, user_mode_i);
          OP_ROOT_WR: root_pte[entry_index_i] = entry_value_i;
          OP_LEAF_WR: begin
            if (table_slot_i < POOL_TABLES) begin
              leaf_pte[int'(table_slot_i) * TABLE_ENTRIES + int'(entry_index_i)] = entry_value_i;
            end
          end
          default: ;
        endcase
        expected_xlat.push_back(res);
      end
      // config beat
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_XLATE_EN) xlate_en = cfg_data_i;
        else satp_mode = cfg_data_i;
      end
      pending_cnt = expected_xlat.size();
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_sv32_address_translation_top.sv
// testbench top for the sv32 address translation block: clock, reset, stimulus, verdict
`default_nettype none

module tb_sv32_address_translation_top;
  import sv32at_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 220;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [7:0]  PHASE_EN      = 8'b1101_1101;
  localparam logic [7:0]  PHASE_MODE    = 8'b1100_1111;
  localparam int unsigned HOLD_PHASE    = 2;
  localparam int unsigned DRAIN_PHASE   = 4;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SLOW
  } rx_mode_e;

  typedef struct {
    logic [1:0]      op;
    logic [XLEN-1:0] vaddr;
    logic            wr;
    logic            ex;
    logic            usr;
    logic [1:0]      slot;
    logic [9:0]      idx;
    logic [XLEN-1:0] val;
  } walk_req_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic            cfg_index_i = 1'b0;
  logic            cfg_data_i = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [1:0]      op_i = '0;
  logic [XLEN-1:0] vaddr_i = '0;
  logic            is_write_i = 1'b0;
  logic            is_exec_i = 1'b0;
  logic            user_mode_i = 1'b0;
  logic [1:0]      table_slot_i = '0;
  logic [9:0]      entry_index_i = '0;
  logic [XLEN-1:0] entry_value_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [XLEN-1:0] phys_addr_o;
  logic [1:0]      fault_o;

  int unsigned     fail_count;
  int unsigned     pending_cnt;
  int unsigned     cycles = 0;
  int unsigned     hold_asked = 0;
  int unsigned     hold_served = 0;
  logic [9:0]      hot_hi [8];
  logic [9:0]      hot_lo [16];

  sv32_address_translation_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .vaddr_i       (vaddr_i),
    .is_write_i    (is_write_i),
    .is_exec_i     (is_exec_i),
    .user_mode_i   (user_mode_i),
    .table_slot_i  (table_slot_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .phys_addr_o   (phys_addr_o),
    .fault_o       (fault_o)
  );

  sv32at_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .op_i          (op_i),
    .vaddr_i       (vaddr_i),
    .is_write_i    (is_write_i),
    .is_exec_i     (is_exec_i),
    .user_mode_i   (user_mode_i),
    .table_slot_i  (table_slot_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .phys_addr_i   (phys_addr_o),
    .fault_i       (fault_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending_cnt)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // result side: stall pattern of its own, plus long hold-offs on request
  initial begin
    rx_mode_e    rx_mode;
    int unsigned mode_left;
    rx_mode   = RX_FREE;
    mode_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_asked != hold_served) begin
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_served++;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 120);
        end
        mode_left--;
        case (rx_mode)
          RX_FREE: out_ready_i = 1'b1;
          RX_COIN: out_ready_i = 1'($urandom_range(0, 1));
          default: out_ready_i = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic walk_req_t mk_xlate(input logic [XLEN-1:0] va, input logic wr,
                                         input logic ex, input logic usr);
    walk_req_t r;
    r.op    = OP_XLATE;
    r.vaddr = va;
    r.wr    = wr;
    r.ex    = ex;
    r.usr   = usr;
    r.slot  = 2'($urandom);
    r.idx   = 10'($urandom);
    r.val   = $urandom;
    return r;
  endfunction

  function automatic walk_req_t mk_write(input logic [1:0] op, input logic [1:0] slot,
                                         input logic [9:0] idx, input logic [XLEN-1:0] val);
    walk_req_t r;
    r       = mk_xlate($urandom, 1'($urandom), 1'($urandom), 1'($urandom));
    r.op    = op;
    r.slot  = slot;
    r.idx   = idx;
    r.val   = val;
    return r;
  endfunction

  function automatic logic [XLEN-1:0] rand_vaddr();
    if ($urandom_range(0, 9) < 8) begin
      return {hot_hi[$urandom_range(0, 7)], hot_lo[$urandom_range(0, 15)], 12'($urandom)};
    end
    return $urandom;
  endfunction

  function automatic logic [XLEN-1:0] rand_root_pte();
    logic [XLEN-1:0] v;
    int unsigned     pick;
    v    = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // pointer to a pool table
      v[31:12] = 20'($urandom_range(0, POOL_TABLES - 1));
      v[FLAG_V] = 1'b1;
      v[FLAG_R] = 1'b0;
      v[FLAG_W] = 1'b0;
      v[FLAG_X] = 1'b0;
    end else if (pick < 75) begin
      // superpage
      v[FLAG_V] = 1'b1;
      if (v[3:1] == 3'b000) v[FLAG_R + $urandom_range(0, 2)] = 1'b1;
    end else if (pick < 85) begin
      // pointer past the pool
      v[31:12] = 20'($urandom_range(POOL_TABLES, 20'hFFFFF));
      v[FLAG_V] = 1'b1;
      v[3:1]    = 3'b000;
    end else begin
      v[FLAG_V] = 1'b0;
    end
    return v;
  endfunction

  function automatic walk_req_t rand_req();
    walk_req_t   r;
    int unsigned pick;
    r    = mk_xlate(rand_vaddr(), 1'($urandom), 1'($urandom), 1'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      r.op  = OP_ROOT_WR;
      r.idx = ($urandom_range(0, 4) != 0) ? hot_hi[$urandom_range(0, 7)] : 10'($urandom);
      r.val = rand_root_pte();
    end else if (pick < 40) begin
      r.op  = OP_LEAF_WR;
      r.idx = ($urandom_range(0, 4) != 0) ? hot_lo[$urandom_range(0, 15)] : 10'($urandom);
      r.val = $urandom;
      r.val[FLAG_V] = ($urandom_range(0, 9) != 0);
    end else if (pick < 44) begin
      r.op = OP_UNUSED;
    end
    return r;
  endfunction

  task automatic send_req(input walk_req_t r);
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    op_i          = r.op;
    vaddr_i       = r.vaddr;
    is_write_i    = r.wr;
    is_exec_i     = r.ex;
    user_mode_i   = r.usr;
    table_slot_i  = r.slot;
    entry_index_i = r.idx;
    entry_value_i = r.val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic idle_for(input int unsigned n);
    if (n != 0) begin
      @(negedge clk_i);
      in_valid_i    = 1'b0;
      op_i          = 2'($urandom);
      vaddr_i       = $urandom;
      entry_value_i = $urandom;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    idle_for(1);
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_regs(input logic en, input logic mode);
    write_reg(CFG_XLATE_EN, en);
    write_reg(CFG_SATP_MODE, mode);
  endtask

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    for (int i = 0; i < 8; i++) hot_hi[i] = 10'($urandom);
    for (int i = 0; i < 16; i++) hot_lo[i] = 10'($urandom);
    hot_hi[0] = 10'h000;
    hot_hi[1] = 10'h3FF;
    hot_hi[2] = 10'h001;
    hot_lo[0] = 10'h000;
    hot_lo[1] = 10'h3FF;
    hot_lo[2] = 10'h001;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // translation off: addresses pass straight through
    set_regs(1'b0, 1'b0);
    send_req(mk_xlate(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
    send_req(mk_xlate(32'h0000_0000, 1'b0, 1'b0, 1'b0));
    wait_drained();
    set_regs(1'b1, 1'b1);

    // directed walk cases
    send_req(mk_xlate(32'h0000_0000, 1'b0, 1'b0, 1'b0));
    send_req(mk_write(OP_ROOT_WR, 2'd0, 10'h3FF, 32'hFFC0_000F));
    send_req(mk_xlate(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1));
    send_req(mk_write(OP_ROOT_WR, 2'd0, 10'h000, 32'h0000_1001));
    send_req(mk_write(OP_LEAF_WR, 2'd1, 10'h000, 32'hABCD_E01F));
    send_req(mk_xlate(32'h0000_0ABC, 1'b0, 1'b1, 1'b1));
    send_req(mk_write(OP_LEAF_WR, 2'd1, 10'h001, 32'h1234_5003));
    send_req(mk_xlate(32'h0000_1123, 1'b1, 1'b0, 1'b0));
    send_req(mk_xlate(32'h0000_1123, 1'b0, 1'b1, 1'b0));
    send_req(mk_xlate(32'h0000_1123, 1'b0, 1'b0, 1'b1));
    send_req(mk_xlate(32'h0000_1123, 1'b0, 1'b0, 1'b0));
    send_req(mk_write(OP_LEAF_WR, 2'd1, 10'h002, 32'hFFFF_F01E));
    send_req(mk_xlate(32'h0000_2FFF, 1'b1, 1'b0, 1'b0));
    send_req(mk_write(OP_ROOT_WR, 2'd0, 10'h001, 32'h0000_4001));
    send_req(mk_xlate(32'h0040_0000, 1'b0, 1'b1, 1'b0));
    send_req(mk_write(OP_ROOT_WR, 2'd0, 10'h002, 32'h1000_0001));
    send_req(mk_xlate(32'h0080_0000, 1'b1, 1'b0, 1'b1));
    send_req(mk_write(OP_ROOT_WR, 2'd0, 10'h003, 32'h0000_3011));
    send_req(mk_write(OP_LEAF_WR, 2'd3, 10'h3FF, 32'hFFFF_F01D));
    send_req(mk_xlate(32'h00FF_FFFF, 1'b1, 1'b0, 1'b1));
    send_req(mk_write(OP_LEAF_WR, 2'd3, 10'h000, 32'hFFFF_FFFF));
    send_req(mk_xlate(32'h00C0_0000, 1'b1, 1'b1, 1'b1));
    send_req(mk_write(OP_UNUSED, 2'd3, 10'h3FF, 32'hFFFF_FFFF));
    send_req(mk_xlate(32'h00FF_FFFF, 1'b0, 1'b0, 1'b0));

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      set_regs(PHASE_EN[p], PHASE_MODE[p]);
      if (p == HOLD_PHASE) hold_asked++;
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == DRAIN_PHASE && n == PHASE_ITEMS / 2) wait_drained();
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          idle_for(gap);
          burst_left = $urandom_range(1, 24);
        end
        send_req(rand_req());
        burst_left--;
      end
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
